/* design/qrs_pkg.sv */
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int TOL_W  = 16;

    localparam int PROD_W = 2 * DATA_W;
    localparam int DISC_W = 2 * DATA_W + 2;
    localparam int SQRT_W = DISC_W / 2;
    localparam int REM_W  = SQRT_W + 2;
    localparam int NUM_W  = DATA_W + 2;
    localparam int NSGN_W = DATA_W + 3;
    localparam int QNUM_W = NUM_W + FRAC_W;
    localparam int DEN_W  = DATA_W + 1;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_ONE  = 2'd1,
        CLS_TWO  = 2'd2,
        CLS_INF  = 2'd3
    } root_class_t;

    typedef struct packed {
        root_class_t              cls;
        logic                     use_div;
        logic                     two_root;
        logic                     neg1;
        logic                     a_neg;
        logic [NUM_W-1:0]         num1;
        logic signed [NSGN_W-1:0] nb;
        logic [DEN_W-1:0]         den;
    } side_t;

    typedef struct packed {
        root_class_t              cls;
        logic signed [DATA_W-1:0] first_root;
        logic signed [DATA_W-1:0] second_root;
        logic                     overflow;
    } result_t;

endpackage

/* design/qrs_coef_if.sv */
`timescale 1ns / 1ps

interface qrs_coef_if;
    import qrs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] coef_a;
    logic signed [DATA_W-1:0] coef_b;
    logic signed [DATA_W-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

/* design/qrs_root_if.sv */
`timescale 1ns / 1ps

interface qrs_root_if;
    import qrs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               root_class;
    logic signed [DATA_W-1:0] first_root;
    logic signed [DATA_W-1:0] second_root;
    logic                     overflow;

    modport source (output valid, output root_class, output first_root,
                    output second_root, output overflow, input ready);
    modport sink (input valid, input root_class, input first_root,
                  input second_root, input overflow, output ready);
endinterface

/* design/quadratic_root_solver.sv */
`timescale 1ns / 1ps
// Channel  Dir  Handshake         Word
// coef     in   valid/ready       coef_a, coef_b, coef_c (signed Q16.16)
// root     out  valid/ready       root_class, first_root, second_root, overflow
// cfg      in   cfg_we            cfg_wdata = zero_tolerance
//
// One word per cycle in and out while the output buffer is not full; 91 pipeline stages plus
// one in the output buffer:
// 5 front stages (capture, magnitude, 32x32 multiply, discriminant, classify),
// 33 square-root steps, 2 numerator stages, 50 restoring-divide steps, 1 saturation stage.
// rst_n clears valid bits, buffer count and zero_tolerance.
// The whole pipeline holds while the two-entry output buffer is full.

module quadratic_root_solver (
    input  logic                       clk,
    input  logic                       rst_n,
    qrs_coef_if.sink                   coef,
    qrs_root_if.source                 root,
    input  logic                       cfg_we,
    input  logic [qrs_pkg::TOL_W-1:0]  cfg_wdata
);
    import qrs_pkg::*;

    logic              tol_reg;
    logic [TOL_W-1:0]  tol_val_reg;
    logic              adv;
    logic              fr_valid, sq_valid, dv_valid;
    side_t             fr_side, sq_side;
    logic [DISC_W-1:0] fr_disc;
    logic [SQRT_W-1:0] sq_root;
    result_t           dv_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_val_reg <= '0;
            tol_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            tol_val_reg <= cfg_wdata;
            tol_reg     <= 1'b1;
        end
    end

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .tol       (tol_reg ? tol_val_reg : '0),
        .coef      (coef),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_disc  (fr_disc)
    );

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_disc   (fr_disc),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    qrs_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (sq_valid),
        .in_side    (sq_side),
        .in_root    (sq_root),
        .out_valid  (dv_valid),
        .out_result (dv_result)
    );

    qrs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_result (dv_result),
        .adv       (adv),
        .root      (root)
    );

endmodule

/* design/qrs_front.sv */
`timescale 1ns / 1ps

module qrs_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [qrs_pkg::TOL_W-1:0]   tol,
    qrs_coef_if.sink                    coef,
    output logic                        out_valid,
    output qrs_pkg::side_t              out_side,
    output logic [qrs_pkg::DISC_W-1:0]  out_disc
);
    import qrs_pkg::*;

    // capture
    logic                     v0_reg;
    logic signed [DATA_W-1:0] a0_reg, b0_reg, c0_reg;
    // magnitudes
    logic                     v1_reg;
    logic [DATA_W-1:0]        ua1_reg, ub1_reg, uc1_reg;
    logic                     an1_reg, bn1_reg, cn1_reg, za1_reg, zb1_reg, zc1_reg;
    // products
    logic                     v2_reg;
    logic [PROD_W-1:0]        bb2_reg, ac2_reg;
    logic [DATA_W-1:0]        ua2_reg, ub2_reg, uc2_reg;
    logic                     an2_reg, bn2_reg, cn2_reg, za2_reg, zb2_reg, zc2_reg;
    // discriminant
    logic                     v3_reg;
    logic [DISC_W-1:0]        dm3_reg;
    logic                     dneg3_reg;
    logic [DATA_W-1:0]        ua3_reg, ub3_reg, uc3_reg;
    logic                     an3_reg, bn3_reg, cn3_reg, za3_reg, zb3_reg, zc3_reg;
    // setup
    logic                     v4_reg;
    side_t                    side4_reg;
    logic [DISC_W-1:0]        d4_reg;

    logic [DATA_W-1:0]        tol_ext;
    logic [DATA_W-1:0]        ua_next, ub_next, uc_next;
    logic [DISC_W-1:0]        bbw, ac4, dsum, drev;
    logic [DISC_W:0]          ddiff;
    logic [DISC_W-1:0]        dm_next;
    logic                     dneg_next;
    logic [DISC_W-1:0]        thr;
    logic                     dz;
    side_t                    side_next;

    assign coef.ready = adv;
    assign tol_ext    = DATA_W'(tol);

    assign ua_next = a0_reg[DATA_W-1] ? DATA_W'(-a0_reg) : DATA_W'(a0_reg);
    assign ub_next = b0_reg[DATA_W-1] ? DATA_W'(-b0_reg) : DATA_W'(b0_reg);
    assign uc_next = c0_reg[DATA_W-1] ? DATA_W'(-c0_reg) : DATA_W'(c0_reg);

    assign bbw   = DISC_W'(bb2_reg);
    assign ac4   = DISC_W'(ac2_reg) << 2;
    assign dsum  = bbw + ac4;
    assign ddiff = {1'b0, bbw} - {1'b0, ac4};
    assign drev  = ac4 - bbw;

    always_comb
    begin
        if (an2_reg != cn2_reg)
        begin
            dm_next   = dsum;
            dneg_next = 1'b0;
        end
        else if (!ddiff[DISC_W])
        begin
            dm_next   = ddiff[DISC_W-1:0];
            dneg_next = 1'b0;
        end
        else
        begin
            dm_next   = drev;
            dneg_next = 1'b1;
        end
    end

    assign thr = DISC_W'(tol) << FRAC_W;
    assign dz  = (dm3_reg <= thr);

    always_comb
    begin
        side_next          = '0;
        side_next.cls      = CLS_NONE;
        side_next.a_neg    = an3_reg;
        side_next.nb       = bn3_reg ? $signed(NSGN_W'(ub3_reg)) : -$signed(NSGN_W'(ub3_reg));
        side_next.den      = DEN_W'(1);
        if (za3_reg)
        begin
            if (zb3_reg)
            begin
                side_next.cls = zc3_reg ? CLS_INF : CLS_NONE;
            end
            else
            begin
                side_next.cls = CLS_ONE;
                if (!zc3_reg)
                begin
                    side_next.use_div = 1'b1;
                    side_next.num1    = NUM_W'(uc3_reg);
                    side_next.neg1    = (cn3_reg == bn3_reg);
                    side_next.den     = {1'b0, ub3_reg};
                end
            end
        end
        else if (dz)
        begin
            side_next.cls     = CLS_ONE;
            side_next.use_div = 1'b1;
            side_next.num1    = NUM_W'(ub3_reg);
            side_next.neg1    = (bn3_reg == an3_reg);
            side_next.den     = {ua3_reg, 1'b0};
        end
        else if (!dneg3_reg)
        begin
            side_next.cls      = CLS_TWO;
            side_next.use_div  = 1'b1;
            side_next.two_root = 1'b1;
            side_next.den      = {ua3_reg, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= coef.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a0_reg <= coef.coef_a;
            b0_reg <= coef.coef_b;
            c0_reg <= coef.coef_c;

            ua1_reg <= ua_next;
            ub1_reg <= ub_next;
            uc1_reg <= uc_next;
            an1_reg <= a0_reg[DATA_W-1];
            bn1_reg <= b0_reg[DATA_W-1];
            cn1_reg <= c0_reg[DATA_W-1];
            za1_reg <= (ua_next <= tol_ext);
            zb1_reg <= (ub_next <= tol_ext);
            zc1_reg <= (uc_next <= tol_ext);

            bb2_reg <= PROD_W'(ub1_reg) * PROD_W'(ub1_reg);
            ac2_reg <= PROD_W'(ua1_reg) * PROD_W'(uc1_reg);
            ua2_reg <= ua1_reg;
            ub2_reg <= ub1_reg;
            uc2_reg <= uc1_reg;
            an2_reg <= an1_reg;
            bn2_reg <= bn1_reg;
            cn2_reg <= cn1_reg;
            za2_reg <= za1_reg;
            zb2_reg <= zb1_reg;
            zc2_reg <= zc1_reg;

            dm3_reg   <= dm_next;
            dneg3_reg <= dneg_next;
            ua3_reg   <= ua2_reg;
            ub3_reg   <= ub2_reg;
            uc3_reg   <= uc2_reg;
            an3_reg   <= an2_reg;
            bn3_reg   <= bn2_reg;
            cn3_reg   <= cn2_reg;
            za3_reg   <= za2_reg;
            zb3_reg   <= zb2_reg;
            zc3_reg   <= zc2_reg;

            side4_reg <= side_next;
            d4_reg    <= dm3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_side  = side4_reg;
    assign out_disc  = d4_reg;

endmodule

/* design/qrs_sqrt.sv */
`timescale 1ns / 1ps

module qrs_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  qrs_pkg::side_t              in_side,
    input  logic [qrs_pkg::DISC_W-1:0]  in_disc,
    output logic                        out_valid,
    output qrs_pkg::side_t              out_side,
    output logic [qrs_pkg::SQRT_W-1:0]  out_root
);
    import qrs_pkg::*;

    logic              v_reg    [1:SQRT_W];
    side_t             side_reg [1:SQRT_W];
    logic [DISC_W-1:0] d_reg    [1:SQRT_W];
    logic [REM_W-1:0]  rem_reg  [1:SQRT_W];
    logic [SQRT_W-1:0] root_reg [1:SQRT_W];

    for (genvar i = 0; i < SQRT_W; i++)
    begin : g_step
        logic              src_v;
        side_t             src_side;
        logic [DISC_W-1:0] src_d;
        logic [REM_W-1:0]  src_rem;
        logic [SQRT_W-1:0] src_root;
        logic [REM_W+1:0]  rem_wide;
        logic [REM_W+1:0]  trial;
        logic              take;
        logic [REM_W-1:0]  rem_next;
        logic [SQRT_W-1:0] root_next;

        if (i == 0)
        begin : g_first
            assign src_v    = in_valid;
            assign src_side = in_side;
            assign src_d    = in_disc;
            assign src_rem  = '0;
            assign src_root = '0;
        end
        else
        begin : g_rest
            assign src_v    = v_reg[i];
            assign src_side = side_reg[i];
            assign src_d    = d_reg[i];
            assign src_rem  = rem_reg[i];
            assign src_root = root_reg[i];
        end

        assign rem_wide  = {src_rem, src_d[DISC_W-1 -: 2]};
        assign trial     = (REM_W + 2)'({src_root, 2'b01});
        assign take      = (rem_wide >= trial);
        assign rem_next  = take ? REM_W'(rem_wide - trial) : REM_W'(rem_wide);
        assign root_next = {src_root[SQRT_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i+1] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[i+1] <= src_side;
                d_reg[i+1]    <= src_d << 2;
                rem_reg[i+1]  <= rem_next;
                root_reg[i+1] <= root_next;
            end
        end
    end

    assign out_valid = v_reg[SQRT_W];
    assign out_side  = side_reg[SQRT_W];
    assign out_root  = root_reg[SQRT_W];

endmodule

/* design/qrs_div.sv */
`timescale 1ns / 1ps

module qrs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  qrs_pkg::side_t              in_side,
    input  logic [qrs_pkg::SQRT_W-1:0]  in_root,
    output logic                        out_valid,
    output qrs_pkg::result_t            out_result
);
    import qrs_pkg::*;

    localparam logic [QNUM_W-1:0] MAXPOS = QNUM_W'((64'd1 << (DATA_W - 1)) - 64'd1);
    localparam logic [QNUM_W-1:0] MAXNEG = QNUM_W'(64'd1 << (DATA_W - 1));

    // signed numerators
    logic                     va_reg;
    side_t                    sa_reg;
    logic signed [NSGN_W-1:0] t_reg [2];
    // magnitudes
    logic                     vb_reg;
    side_t                    sb_reg;
    logic [NUM_W-1:0]         num_reg [2];
    logic                     neg_reg [2];

    logic                     v_reg    [1:QNUM_W];
    side_t                    side_reg [1:QNUM_W];
    logic                     ng_reg   [1:QNUM_W][2];
    logic [DEN_W-1:0]         rem_reg  [1:QNUM_W][2];
    logic [QNUM_W-1:0]        nq_reg   [1:QNUM_W][2];

    logic                     vo_reg;
    result_t                  res_reg;

    logic signed [NSGN_W-1:0] s_ext;
    logic [NUM_W-1:0]         mag_next [2];
    logic                     neg_next [2];
    logic [DATA_W-1:0]        r_sat [2];
    logic                     o_sat [2];
    result_t                  res_next;

    assign s_ext = $signed(NSGN_W'(in_root));

    for (genvar k = 0; k < 2; k++)
    begin : g_prep
        always_comb
        begin
            if (sa_reg.two_root)
            begin
                mag_next[k] = t_reg[k][NSGN_W-1] ? NUM_W'(-t_reg[k]) : NUM_W'(t_reg[k]);
                neg_next[k] = t_reg[k][NSGN_W-1] != sa_reg.a_neg;
            end
            else
            begin
                mag_next[k] = sa_reg.num1;
                neg_next[k] = sa_reg.neg1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg     <= in_side;
            t_reg[0]   <= in_side.nb - s_ext;
            t_reg[1]   <= in_side.nb + s_ext;
            sb_reg     <= sa_reg;
            num_reg[0] <= mag_next[0];
            num_reg[1] <= mag_next[1];
            neg_reg[0] <= neg_next[0];
            neg_reg[1] <= neg_next[1];
        end
    end

    for (genvar i = 0; i < QNUM_W; i++)
    begin : g_step
        logic              src_v;
        side_t             src_side;
        logic              src_ng  [2];
        logic [DEN_W-1:0]  src_rem [2];
        logic [QNUM_W-1:0] src_nq  [2];

        if (i == 0)
        begin : g_first
            assign src_v    = vb_reg;
            assign src_side = sb_reg;
            for (genvar k = 0; k < 2; k++)
            begin : g_lane
                assign src_ng[k]  = neg_reg[k];
                assign src_rem[k] = '0;
                assign src_nq[k]  = QNUM_W'(num_reg[k]) << FRAC_W;
            end
        end
        else
        begin : g_rest
            assign src_v    = v_reg[i];
            assign src_side = side_reg[i];
            for (genvar k = 0; k < 2; k++)
            begin : g_lane
                assign src_ng[k]  = ng_reg[i][k];
                assign src_rem[k] = rem_reg[i][k];
                assign src_nq[k]  = nq_reg[i][k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i+1] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[i+1] <= src_side;
            end
        end

        for (genvar k = 0; k < 2; k++)
        begin : g_lane_step
            logic [DEN_W:0]   sh;
            logic             take;
            logic [DEN_W-1:0] rem_next;

            assign sh       = {src_rem[k], src_nq[k][QNUM_W-1]};
            assign take     = (sh >= {1'b0, src_side.den});
            assign rem_next = take ? DEN_W'(sh - {1'b0, src_side.den}) : sh[DEN_W-1:0];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ng_reg[i+1][k]  <= src_ng[k];
                    rem_reg[i+1][k] <= rem_next;
                    nq_reg[i+1][k]  <= {src_nq[k][QNUM_W-2:0], take};
                end
            end
        end
    end

    for (genvar k = 0; k < 2; k++)
    begin : g_sat
        logic [QNUM_W-1:0] q;

        assign q = nq_reg[QNUM_W][k];

        always_comb
        begin
            o_sat[k] = 1'b0;
            if (!ng_reg[QNUM_W][k])
            begin
                if (q > MAXPOS)
                begin
                    r_sat[k] = MAXPOS[DATA_W-1:0];
                    o_sat[k] = 1'b1;
                end
                else
                begin
                    r_sat[k] = q[DATA_W-1:0];
                end
            end
            else
            begin
                if (q > MAXNEG)
                begin
                    r_sat[k] = MAXNEG[DATA_W-1:0];
                    o_sat[k] = 1'b1;
                end
                else
                begin
                    r_sat[k] = DATA_W'(-q[DATA_W-1:0]);
                end
            end
        end
    end

    always_comb
    begin
        res_next     = '0;
        res_next.cls = side_reg[QNUM_W].cls;
        if (side_reg[QNUM_W].use_div)
        begin
            res_next.first_root = $signed(r_sat[0]);
            if (side_reg[QNUM_W].two_root)
            begin
                res_next.second_root = $signed(r_sat[1]);
                res_next.overflow    = o_sat[0] | o_sat[1];
            end
            else
            begin
                res_next.second_root = $signed(r_sat[0]);
                res_next.overflow    = o_sat[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            vo_reg <= v_reg[QNUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = vo_reg;
    assign out_result = res_reg;

endmodule

/* design/qrs_out_buf.sv */
`timescale 1ns / 1ps

module qrs_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  qrs_pkg::result_t  in_result,
    output logic              adv,
    qrs_root_if.source        root
);
    import qrs_pkg::*;

    result_t    mem [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push, pop;

    assign adv  = (count_reg != 2'd2);
    assign push = in_valid && adv;
    assign pop  = root.valid && root.ready;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_result;
        end
    end

    assign root.valid       = (count_reg != 2'd0);
    assign root.root_class  = mem[rd_ptr_reg].cls;
    assign root.first_root  = mem[rd_ptr_reg].first_root;
    assign root.second_root = mem[rd_ptr_reg].second_root;
    assign root.overflow    = mem[rd_ptr_reg].overflow;

endmodule
